// File: design/mpse_pkg.sv
// Shared types, tag codes and the scalar-to-frame encoder.
// No dependencies; imported by msgpack_scalar_encoder.
`timescale 1ns / 1ps

package mpse_pkg;

  localparam int FrameBytes = 9;
  localparam int FrameW     = 8 * FrameBytes;
  localparam int CountW     = $clog2(FrameBytes + 1);

  localparam logic [2:0] KIND_SINT  = 3'd0;
  localparam logic [2:0] KIND_UINT  = 3'd1;
  localparam logic [2:0] KIND_BOOL  = 3'd2;
  localparam logic [2:0] KIND_FLOAT = 3'd3;
  localparam logic [2:0] KIND_STR   = 3'd4;

  localparam logic [7:0] TAG_INT8    = 8'hd0;
  localparam logic [7:0] TAG_INT16   = 8'hd1;
  localparam logic [7:0] TAG_INT32   = 8'hd2;
  localparam logic [7:0] TAG_INT64   = 8'hd3;
  localparam logic [7:0] TAG_UINT8   = 8'hcc;
  localparam logic [7:0] TAG_UINT16  = 8'hcd;
  localparam logic [7:0] TAG_UINT32  = 8'hce;
  localparam logic [7:0] TAG_UINT64  = 8'hcf;
  localparam logic [7:0] TAG_TRUE    = 8'hc3;
  localparam logic [7:0] TAG_FALSE   = 8'hc2;
  localparam logic [7:0] TAG_FLOAT32 = 8'hca;
  localparam logic [7:0] TAG_FIXSTR  = 8'ha0;
  localparam logic [7:0] TAG_STR8    = 8'hd9;
  localparam logic [7:0] TAG_STR16   = 8'hda;
  localparam logic [7:0] TAG_STR32   = 8'hdb;

  typedef struct packed {
    logic [FrameW-1:0] data;
    logic [CountW-1:0] count;
  } frame_t;

  function automatic frame_t encode(input logic [2:0] kind, input logic [63:0] v,
                                    input logic [31:0] len);
    frame_t f;
    f.data  = '0;
    f.count = '0;
    case (kind)
      KIND_SINT: begin
        if ((~|v[63:7]) || (&v[63:5])) begin
          f.data  = {v[7:0], 64'h0};
          f.count = CountW'(1);
        end else if ((~|v[63:7]) || (&v[63:7])) begin
          f.data  = {TAG_INT8, v[7:0], 56'h0};
          f.count = CountW'(2);
        end else if ((~|v[63:15]) || (&v[63:15])) begin
          f.data  = {TAG_INT16, v[15:0], 48'h0};
          f.count = CountW'(3);
        end else if ((~|v[63:31]) || (&v[63:31])) begin
          f.data  = {TAG_INT32, v[31:0], 32'h0};
          f.count = CountW'(5);
        end else begin
          f.data  = {TAG_INT64, v};
          f.count = CountW'(9);
        end
      end
      KIND_UINT: begin
        if (~|v[63:7]) begin
          f.data  = {v[7:0], 64'h0};
          f.count = CountW'(1);
        end else if (~|v[63:8]) begin
          f.data  = {TAG_UINT8, v[7:0], 56'h0};
          f.count = CountW'(2);
        end else if (~|v[63:16]) begin
          f.data  = {TAG_UINT16, v[15:0], 48'h0};
          f.count = CountW'(3);
        end else if (~|v[63:32]) begin
          f.data  = {TAG_UINT32, v[31:0], 32'h0};
          f.count = CountW'(5);
        end else begin
          f.data  = {TAG_UINT64, v};
          f.count = CountW'(9);
        end
      end
      KIND_BOOL: begin
        f.data  = {(v[0] ? TAG_TRUE : TAG_FALSE), 64'h0};
        f.count = CountW'(1);
      end
      KIND_FLOAT: begin
        f.data  = {TAG_FLOAT32, v[31:0], 32'h0};
        f.count = CountW'(5);
      end
      KIND_STR: begin
        if (~|len[31:5]) begin
          f.data  = {(TAG_FIXSTR | {3'b000, len[4:0]}), 64'h0};
          f.count = CountW'(1);
        end else if (~|len[31:8]) begin
          f.data  = {TAG_STR8, len[7:0], 56'h0};
          f.count = CountW'(2);
        end else if (~|len[31:16]) begin
          f.data  = {TAG_STR16, len[15:0], 48'h0};
          f.count = CountW'(3);
        end else begin
          f.data  = {TAG_STR32, len, 32'h0};
          f.count = CountW'(5);
        end
      end
      default: begin
        f.data  = '0;
        f.count = '0;
      end
    endcase
    return f;
  endfunction

endpackage

// File: design/msgpack_scalar_encoder.sv
// Channel  Dir  Handshake               Payload
// in       in   in_valid_i / in_stall_o  kind_i, value_i, length_i
// out      out  out_valid_o / out_stall_i out_byte_o, last_o
// An accepted scalar is encoded in one pass into a frame register of up to nine
// bytes, then shifted out one byte per cycle while out_stall_i is low; an item
// is 1, 2, 3, 5 or 9 bytes. The next scalar is taken in the cycle its
// predecessor's last byte leaves. Unknown kinds are taken and yield no bytes.
// Reset empties the frame register. Depends on mpse_pkg.
`timescale 1ns / 1ps

module msgpack_scalar_encoder
  import mpse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [63:0] value_i,
  input  logic [31:0] length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);

  logic [FrameW-1:0] data_q, data_d;
  logic [CountW-1:0] count_q, count_d;
  frame_t            enc;
  logic              pop, in_accept;

  assign enc        = encode(kind_i, value_i, length_i);
  assign out_valid_o = (count_q != '0);
  assign out_byte_o = data_q[FrameW-1 -: 8];
  assign last_o     = (count_q == CountW'(1));
  assign pop        = out_valid_o && !out_stall_i;
  assign in_stall_o = (count_q > CountW'(1)) || (last_o && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    data_d  = data_q;
    count_d = count_q;
    if (in_accept) begin
      data_d  = enc.data;
      count_d = enc.count;
    end else if (pop) begin
      data_d  = {data_q[FrameW-9:0], 8'h00};
      count_d = count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule
